// ===== design/frcg_pkg.sv =====
// Shared types, constants and the clock profile table of the frame rate governor.
package frcg_pkg;

  localparam int unsigned TimeBitsDefault = 48;
  localparam int unsigned AddrBits        = 5;
  localparam int unsigned DataBits        = 32;

  // Register map, word index into the configuration space
  typedef enum logic [2:0] {
    RegSecondLen = 3'd0,
    RegAdjustInt = 3'd1,
    RegWindow    = 3'd2,
    RegJump      = 3'd3,
    RegStart     = 3'd4
  } reg_idx_e;

  // Function code of an input word
  typedef enum logic {
    FuncFrame   = 1'b0,
    FuncRestart = 1'b1
  } func_e;

  localparam logic [23:0] SecondLenReset = 24'd1000000;
  localparam logic [27:0] AdjustIntReset = 28'd5000000;
  localparam logic [31:0] WindowReset    = 32'd60000000;
  localparam logic [7:0]  JumpReset      = 8'd6;
  localparam logic [2:0]  StartReset     = 3'd2;

  localparam logic [7:0]  PriorReset     = 8'd50;
  localparam logic [1:0]  TriesReset     = 2'd2;
  localparam logic [7:0]  CountMax       = 8'd255;
  localparam logic [2:0]  MaxProfile     = 3'd4;
  localparam logic [2:0]  ShellProfile   = 3'd2;

  typedef struct packed {
    logic [23:0] second_len;
    logic [27:0] adjust_int;
    logic [31:0] window;
    logic [7:0]  jump;
    logic [2:0]  start;
  } cfg_t;

  typedef struct packed {
    logic [9:0] cpu;
    logic [9:0] bus;
    logic [9:0] gpu_es4;
    logic [9:0] xbar;
    logic [9:0] gpu;
  } clocks_t;

  typedef struct packed {
    logic [2:0] profile;
    logic       changed;
    logic [7:0] rate;
    clocks_t    clocks;
  } result_t;

  // Clock frequencies in MHz for each profile
  function automatic clocks_t profile_clocks(input logic [2:0] prof);
    clocks_t c;
    case (prof)
      3'd0: c = '{cpu: 10'd111, bus: 10'd111, gpu_es4: 10'd111, xbar: 10'd111, gpu: 10'd111};
      3'd1: c = '{cpu: 10'd266, bus: 10'd166, gpu_es4: 10'd166, xbar: 10'd111, gpu: 10'd166};
      3'd2: c = '{cpu: 10'd444, bus: 10'd222, gpu_es4: 10'd222, xbar: 10'd166, gpu: 10'd222};
      3'd3: c = '{cpu: 10'd444, bus: 10'd222, gpu_es4: 10'd222, xbar: 10'd166, gpu: 10'd333};
      default: c = '{cpu: 10'd500, bus: 10'd222, gpu_es4: 10'd222, xbar: 10'd166, gpu: 10'd333};
    endcase
    return c;
  endfunction

endpackage

// ===== design/frame_rate_clock_governor.sv =====
// Top level of the frame rate clock governor: input and result registers.
//
// Usage: each input word on the in_* channel is a frame event (func 0) or a
// restart (func 1) with a microsecond timestamp and the shell flag. Every
// accepted word yields exactly one result word on the out_* channel with the
// profile, a change flag, the measured frame rate and the cpu, bus, gpu_es4, xbar and gpu frequencies of the
// profile. Both channels use valid/ready.
// Path: a word accepted into the input register passes the governor logic
// and lands in the result register when that register is free or drained.
// Throughput: one word per cycle while out_ready_i stays high, set by the
// single governor pass between the input and result registers.
// Stall: while the result waits, the input register can still take one more
// word; with both registers full, in_ready_o drops until out_ready_i returns.
// Reset: empties both registers, loads the configuration defaults and the
// governor state (profile 2, prior rate 50, two step-down tries).
// Configuration is to be written over the APB-style port only while the
// block is idle; the block itself does not enforce this.
module frame_rate_clock_governor #(
  parameter int unsigned TIME_BITS = frcg_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frcg_pkg::AddrBits-1:0] paddr,
  input  logic [frcg_pkg::DataBits-1:0] pwdata,
  output logic [frcg_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [TIME_BITS-1:0]          time_us_i,
  input  logic                          in_shell_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    profile_o,
  output logic                          profile_changed_o,
  output logic [7:0]                    frame_rate_o,
  output logic [9:0]                    cpu_mhz_o,
  output logic [9:0]                    bus_mhz_o,
  output logic [9:0]                    gpu_es4_mhz_o,
  output logic [9:0]                    xbar_mhz_o,
  output logic [9:0]                    gpu_mhz_o
);
  import frcg_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_q;

  logic                 in_valid_q;
  logic                 func_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 shell_q;
  logic                 out_valid_q;
  logic                 in_take;
  logic                 step;

  frcg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a word on when the result register is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  frcg_governor #(
    .TIME_BITS (TIME_BITS)
  ) u_gov (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (step),
    .func_i     (func_q),
    .time_us_i  (time_q),
    .in_shell_i (shell_q),
    .res_o      (res)
  );

  // Hold the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q  <= func_i;
      time_q  <= time_us_i;
      shell_q <= in_shell_i;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign profile_o         = res_q.profile;
  assign profile_changed_o = res_q.changed;
  assign frame_rate_o      = res_q.rate;
  assign cpu_mhz_o         = res_q.clocks.cpu;
  assign bus_mhz_o         = res_q.clocks.bus;
  assign gpu_es4_mhz_o     = res_q.clocks.gpu_es4;
  assign xbar_mhz_o        = res_q.clocks.xbar;
  assign gpu_mhz_o         = res_q.clocks.gpu;

  // A word taken while the input register cannot drain stays held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !step) |=> in_valid_q)
    else $error("accepted word lost in input register");

  // A word passed on always shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> out_valid_q)
    else $error("governor pass without result");

endmodule

// ===== design/frcg_apb_regs.sv =====
// Configuration register file behind the APB-style port.
module frcg_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frcg_pkg::AddrBits-1:0] paddr,
  input  logic [frcg_pkg::DataBits-1:0] pwdata,
  output logic [frcg_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output frcg_pkg::cfg_t                cfg_o
);
  import frcg_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_len <= SecondLenReset;
      cfg_q.adjust_int <= AdjustIntReset;
      cfg_q.window     <= WindowReset;
      cfg_q.jump       <= JumpReset;
      cfg_q.start      <= StartReset;
    end else if (wr_en) begin
      case (idx)
        RegSecondLen: cfg_q.second_len <= pwdata[23:0];
        RegAdjustInt: cfg_q.adjust_int <= pwdata[27:0];
        RegWindow:    cfg_q.window     <= pwdata[31:0];
        RegJump:      cfg_q.jump       <= pwdata[7:0];
        RegStart:     cfg_q.start      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero beyond the map
  always_comb begin
    case (idx)
      RegSecondLen: prdata = DataBits'(cfg_q.second_len);
      RegAdjustInt: prdata = DataBits'(cfg_q.adjust_int);
      RegWindow:    prdata = DataBits'(cfg_q.window);
      RegJump:      prdata = DataBits'(cfg_q.jump);
      RegStart:     prdata = DataBits'(cfg_q.start);
      default:      prdata = '0;
    endcase
  end

  // Start profile write is held exactly as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && idx == RegStart) |=> (cfg_q.start == $past(pwdata[2:0])))
    else $error("start profile register not updated");

endmodule

// ===== design/frcg_governor.sv =====
// Governor state and the single-pass decision logic for one frame word.
module frcg_governor #(
  parameter int unsigned TIME_BITS = frcg_pkg::TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frcg_pkg::cfg_t       cfg_i,
  input  logic                 step_i,
  input  logic                 func_i,
  input  logic [TIME_BITS-1:0] time_us_i,
  input  logic                 in_shell_i,
  output frcg_pkg::result_t    res_o
);
  import frcg_pkg::*;

  logic [2:0]           profile_q, profile_d;
  logic [7:0]           count_q, count_d;
  logic [7:0]           rate_q, rate_d;
  logic [7:0]           peak_q, peak_d;
  logic [7:0]           prior_q, prior_d;
  logic [1:0]           tries_q, tries_d;
  logic [27:0]          interval_q, interval_d;
  logic [TIME_BITS-1:0] sec_mark_q, sec_mark_d;
  logic [TIME_BITS-1:0] adj_mark_q, adj_mark_d;
  logic [TIME_BITS-1:0] win_mark_q, win_mark_d;

  logic       changed;
  logic [7:0] count_inc;
  logic [7:0] peak_n;
  logic [7:0] diff;
  logic       sec_hit, adj_hit, win_hit;

  function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] mark,
                                   input logic [TIME_BITS-1:0] span);
    logic [TIME_BITS-1:0] delta;
    delta = now - mark;
    return (now >= mark) && (delta > span);
  endfunction

  assign count_inc = (count_q == CountMax) ? CountMax : count_q + 8'd1;
  assign sec_hit   = elapsed(time_us_i, sec_mark_q, TIME_BITS'(cfg_i.second_len));
  assign adj_hit   = elapsed(time_us_i, adj_mark_q, TIME_BITS'(interval_q));
  assign win_hit   = elapsed(time_us_i, win_mark_q, TIME_BITS'(cfg_i.window));

  // Work out the next state for the word in the input register
  always_comb begin
    profile_d  = profile_q;
    count_d    = count_q;
    rate_d     = rate_q;
    peak_d     = peak_q;
    prior_d    = prior_q;
    tries_d    = tries_q;
    interval_d = interval_q;
    sec_mark_d = sec_mark_q;
    adj_mark_d = adj_mark_q;
    win_mark_d = win_mark_q;
    changed    = 1'b0;
    peak_n     = peak_q;
    diff       = '0;

    if (func_e'(func_i) == FuncRestart) begin
      count_d    = '0;
      sec_mark_d = '0;
      adj_mark_d = '0;
      win_mark_d = '0;
      peak_d     = '0;
      prior_d    = PriorReset;
      tries_d    = TriesReset;
      profile_d  = (cfg_i.start > MaxProfile) ? MaxProfile : cfg_i.start;
      changed    = 1'b1;
    end else begin
      // Count the frame and close the measuring period
      count_d = count_inc;
      if (sec_hit) begin
        sec_mark_d = time_us_i;
        rate_d     = count_inc;
        count_d    = '0;
      end

      // Track the peak rate less one
      if (rate_d != 8'd0 && (rate_d - 8'd1) > peak_q) begin
        peak_n = rate_d - 8'd1;
      end
      peak_d = peak_n;

      diff = (rate_d >= prior_q) ? rate_d - prior_q : prior_q - rate_d;

      if (in_shell_i) begin
        if (profile_q != ShellProfile) begin
          profile_d = ShellProfile;
          changed   = 1'b1;
        end
      end else begin
        // Decide on a profile move at the end of the interval
        if (adj_hit) begin
          adj_mark_d = time_us_i;
          interval_d = cfg_i.adjust_int;
          if ((diff > cfg_i.jump || rate_d < peak_n) && profile_q < MaxProfile) begin
            tries_d   = (tries_q != 2'd0) ? tries_q - 2'd1 : 2'd0;
            profile_d = profile_q + 3'd1;
            changed   = 1'b1;
          end else if (tries_q != 2'd0 && diff == 8'd0 && profile_q > 3'd1) begin
            interval_d = {3'b000, cfg_i.second_len, 1'b0};
            profile_d  = profile_q - 3'd1;
            changed    = 1'b1;
          end
          prior_d = rate_d;
        end
        // Clear the peak and set one step-down try at the end of the long window
        if (win_hit) begin
          win_mark_d = time_us_i;
          tries_d    = 2'd1;
          peak_d     = '0;
        end
      end
    end
  end

  // Advance the governor state when a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q  <= ShellProfile;
      count_q    <= '0;
      rate_q     <= '0;
      peak_q     <= '0;
      prior_q    <= PriorReset;
      tries_q    <= TriesReset;
      interval_q <= AdjustIntReset;
      sec_mark_q <= '0;
      adj_mark_q <= '0;
      win_mark_q <= '0;
    end else if (step_i) begin
      profile_q  <= profile_d;
      count_q    <= count_d;
      rate_q     <= rate_d;
      peak_q     <= peak_d;
      prior_q    <= prior_d;
      tries_q    <= tries_d;
      interval_q <= interval_d;
      sec_mark_q <= sec_mark_d;
      adj_mark_q <= adj_mark_d;
      win_mark_q <= win_mark_d;
    end
  end

  assign res_o.profile = profile_d;
  assign res_o.changed = changed;
  assign res_o.rate    = rate_d;
  assign res_o.clocks  = profile_clocks(profile_d);

  assert property (@(posedge clk_i) disable iff (!rst_ni) profile_q <= MaxProfile)
    else $error("profile out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) tries_q <= TriesReset)
    else $error("step-down tries above start value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && profile_d != profile_q) |-> res_o.changed)
    else $error("profile moved without change flag");

endmodule
